// ===== design/texture_mip_layout_generator_assert.svh =====
// Assertion macros shared by the layout generator.
`ifndef TEXTURE_MIP_LAYOUT_GENERATOR_ASSERT_SVH
`define TEXTURE_MIP_LAYOUT_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMLG_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMLG_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== design/tmlg_pkg.sv =====
package tmlg_pkg;

  // parameter defaults
  localparam int MAX_LEVELS_DEF  = 15;
  localparam int DIM_BITS_DEF    = 15;
  localparam int OFFSET_BITS_DEF = 48;

  // fixed field widths
  localparam int DIM_FIELD_W   = 15;
  localparam int DEPTH_W       = 12;
  localparam int COUNT_W       = 4;
  localparam int OFF_FIELD_W   = 48;
  localparam int BYTES_FIELD_W = 33;
  localparam int ROWP_W        = 19;
  localparam int LIMIT_W       = 48;
  localparam int KIND_W        = 2;
  localparam int BPP_W         = 8;
  localparam int LVL_FIELD_W   = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT = 2'd2;

  // block kinds; the unused code falls back to linear
  localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLK8   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BLK16  = 2'd2;

  localparam logic [BPP_W-1:0] BPP_RESET = 8'd32;
  localparam logic [4:0]       BPE_8     = 5'd8;
  localparam logic [4:0]       BPE_16    = 5'd16;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== design/texture_mip_layout_generator.sv =====
// One input transaction yields level_count results (clamped to MAX_LEVELS), one per mip level.
// Per level: a setup state, then three products on the shared shift-add multiplier (width times bits
// per pixel or block size, row bytes times the row count, slice bytes times the depth), each consuming
// its second operand one bit a cycle up to the highest set bit, then the offset advance and the emit,
// which output stalls can hold. Input is taken only between slices.
// Synchronous reset: idle, no result pending, running offset 0, registers at their defaults.
module texture_mip_layout_generator import tmlg_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int DIM_BITS    = DIM_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DIM_FIELD_W-1:0]   base_width,
  input  logic [DIM_FIELD_W-1:0]   base_height,
  input  logic [DEPTH_W-1:0]       base_depth,
  input  logic [COUNT_W-1:0]       level_count,
  input  logic                     first_slice,
  input  logic [OFF_FIELD_W-1:0]   start_offset,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LVL_FIELD_W-1:0]   level_index,
  output logic [OFF_FIELD_W-1:0]   level_offset,
  output logic [BYTES_FIELD_W-1:0] level_bytes,
  output logic [ROWP_W-1:0]        row_pitch,
  output logic [BYTES_FIELD_W-1:0] depth_pitch,
  output logic                     overrun,
  output logic                     last_level
);

  localparam int ROW_W   = DIM_BITS + 5;
  localparam int BYTES_W = 2 * DIM_BITS + 5;
  localparam int MB_W    = (DIM_BITS > DEPTH_W) ? DIM_BITS : DEPTH_W;
  localparam int PROD_W  = BYTES_W + MB_W;
  localparam int SUM_W   = ((OFFSET_BITS > PROD_W) ? OFFSET_BITS : PROD_W) + 1;
  localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
  localparam int CNT_X_W = LVL_W + COUNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ROW    = 6'b000010,
    S_WROW   = 6'b000100,
    S_WBYTES = 6'b001000,
    S_WADV   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;

  logic [KIND_W-1:0]      blk_kind;
  logic [BPP_W-1:0]       bpp;
  logic [LIMIT_W-1:0]     data_limit;
  logic [OFFSET_BITS-1:0] run_off;
  logic [OFFSET_BITS-1:0] nxt;
  logic [DIM_BITS-1:0]    w;
  logic [DIM_BITS-1:0]    h;
  logic [DEPTH_W-1:0]     d;
  logic [LVL_W-1:0]       cnt;
  logic [LVL_W-1:0]       lvl;
  logic [ROW_W-1:0]       row;
  logic [BYTES_W-1:0]     bytes;

  mul_stat_t              mul_st;
  logic                   mul_start;
  logic [BYTES_W-1:0]     mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [PROD_W-1:0]      prod;

  logic                   linear;
  logic [DIM_BITS-1:0]    blk_w;
  logic [DIM_BITS-1:0]    blk_h;
  logic [DIM_BITS-1:0]    rows_cur;
  logic [PROD_W:0]        rnd;
  logic [ROW_W-1:0]       row_new;
  logic [SUM_W-1:0]       sum;
  logic [OFFSET_BITS-1:0] nxt_new;
  logic [CNT_X_W-1:0]     cnt_x;
  logic [LVL_W-1:0]       cnt_clamp;
  logic                   in_acc;
  logic                   emit_ok;
  logic                   is_last;
  logic                   in_mul_wait;
  logic [DIM_BITS-1:0]    w_half;
  logic [DIM_BITS-1:0]    h_half;
  logic [DEPTH_W-1:0]     d_half;
  logic [ROWP_W-1:0]      row_sat;
  logic [BYTES_FIELD_W-1:0] bytes_sat;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign emit_ok  = (state == S_EMIT) && (!out_valid || out_ready);

  assign in_mul_wait = (state == S_WROW) || (state == S_WBYTES) || (state == S_WADV);

  assign linear = !((blk_kind == KIND_BLK8) || (blk_kind == KIND_BLK16));

  // 4x4 block count, zero stays zero
  assign blk_w = (w == '0) ? '0 : DIM_BITS'(({1'b0, w} + (DIM_BITS + 1)'(3)) >> 2);
  assign blk_h = (h == '0) ? '0 : DIM_BITS'(({1'b0, h} + (DIM_BITS + 1)'(3)) >> 2);
  assign rows_cur = linear ? h : blk_h;

  // linear rows round bits up to whole bytes
  assign rnd     = {1'b0, prod} + (PROD_W + 1)'(7);
  assign row_new = linear ? ROW_W'(rnd >> 3) : ROW_W'(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ROW: begin
        mul_a = linear ? BYTES_W'(w) : BYTES_W'(blk_w);
        if (linear) begin
          mul_b = MB_W'(bpp);
        end else begin
          mul_b = (blk_kind == KIND_BLK8) ? MB_W'(BPE_8) : MB_W'(BPE_16);
        end
      end
      S_WROW: begin
        mul_a = BYTES_W'(row_new);
        mul_b = MB_W'(rows_cur);
      end
      S_WBYTES: begin
        mul_a = BYTES_W'(prod);
        mul_b = MB_W'(d);
      end
      S_IDLE, S_WADV, S_EMIT: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state == S_ROW) ||
                     (mul_st.done && ((state == S_WROW) || (state == S_WBYTES)));

  tmlg_ser_mul #(
    .A_W (BYTES_W),
    .B_W (MB_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_st),
    .product (prod)
  );

  // saturating offset advance
  assign sum     = SUM_W'(run_off) + SUM_W'(prod);
  assign nxt_new = (sum > SUM_W'({OFFSET_BITS{1'b1}})) ? {OFFSET_BITS{1'b1}}
                                                       : OFFSET_BITS'(sum);

  assign row_sat = ((ROW_W + ROWP_W)'(row) > (ROW_W + ROWP_W)'({ROWP_W{1'b1}}))
                   ? {ROWP_W{1'b1}} : ROWP_W'(row);
  assign bytes_sat = ((BYTES_W + BYTES_FIELD_W)'(bytes) >
                      (BYTES_W + BYTES_FIELD_W)'({BYTES_FIELD_W{1'b1}}))
                     ? {BYTES_FIELD_W{1'b1}} : BYTES_FIELD_W'(bytes);

  assign cnt_x     = CNT_X_W'(level_count);
  assign cnt_clamp = (cnt_x > CNT_X_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : LVL_W'(cnt_x);
  assign is_last   = (({1'b0, lvl} + (LVL_W + 1)'(1)) == {1'b0, cnt});

  assign w_half = ((w >> 1) == '0) ? DIM_BITS'(1) : (w >> 1);
  assign h_half = ((h >> 1) == '0) ? DIM_BITS'(1) : (h >> 1);
  assign d_half = ((d >> 1) == '0) ? DEPTH_W'(1) : (d >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_kind   <= KIND_LINEAR;
      bpp        <= BPP_RESET;
      data_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_KIND: blk_kind   <= KIND_W'(cfg_data);
        CFG_BPP:        bpp        <= BPP_W'(cfg_data);
        CFG_DATA_LIMIT: data_limit <= LIMIT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_off   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (first_slice) begin
              run_off <= OFFSET_BITS'(start_offset);
            end
            state <= (cnt_clamp == '0) ? S_IDLE : S_ROW;
          end
        end
        S_ROW:    state <= S_WROW;
        S_WROW:   if (mul_st.done) state <= S_WBYTES;
        S_WBYTES: if (mul_st.done) state <= S_WADV;
        S_WADV:   if (mul_st.done) state <= S_EMIT;
        S_EMIT: begin
          if (emit_ok) begin
            run_off <= nxt;
            state   <= is_last ? S_IDLE : S_ROW;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      w   <= DIM_BITS'(base_width);
      h   <= DIM_BITS'(base_height);
      d   <= base_depth;
      cnt <= cnt_clamp;
      lvl <= '0;
    end
    if ((state == S_WROW) && mul_st.done) begin
      row <= row_new;
    end
    if ((state == S_WBYTES) && mul_st.done) begin
      bytes <= BYTES_W'(prod);
    end
    if ((state == S_WADV) && mul_st.done) begin
      nxt <= nxt_new;
    end
    if (emit_ok) begin
      level_index  <= LVL_FIELD_W'(lvl);
      level_offset <= OFF_FIELD_W'(run_off);
      level_bytes  <= bytes_sat;
      row_pitch    <= row_sat;
      depth_pitch  <= bytes_sat;
      overrun      <= ((OFFSET_BITS + LIMIT_W)'(nxt) >= (OFFSET_BITS + LIMIT_W)'(data_limit));
      last_level   <= is_last;
      lvl          <= lvl + LVL_W'(1);
      w            <= w_half;
      h            <= h_half;
      d            <= d_half;
    end
  end

`include "texture_mip_layout_generator_assert.svh"

  `TMLG_ASSERT_NOW(a_idle_mul_quiet, in_ready, !mul_st.busy && !mul_st.done, "mul busy in idle")
  `TMLG_ASSERT_NOW(a_done_in_wait, mul_st.done, in_mul_wait, "mul done outside wait")
  `TMLG_ASSERT_NEXT(a_offset_grows, !in_ready, run_off >= $past(run_off), "offset decreased")
  `TMLG_ASSERT_NOW(a_level_bound, !in_ready, (lvl < cnt) && (cnt != '0), "level past count")

endmodule

// ===== design/tmlg_ser_mul.sv =====
module tmlg_ser_mul import tmlg_pkg::*; #(
  parameter int A_W = 35,
  parameter int B_W = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output mul_stat_t            stat,
  output logic [A_W+B_W-1:0]   product
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] a_sr;
  logic [P_W-1:0] acc;
  logic [B_W-1:0] b_sr;
  logic           busy;
  logic           done;

  // one multiplier bit per cycle; stops once the remaining bits are zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ((b_sr >> 1) == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sr <= P_W'(a);
      b_sr <= b;
    end else if (busy) begin
      if (b_sr[0]) begin
        acc <= acc + a_sr;
      end
      a_sr <= a_sr << 1;
      b_sr <= b_sr >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule
